>>> hdl/char_grid_store_with_overflow_top_assert.svh
// Assertion macros for the character grid store.
`ifndef CHAR_GRID_STORE_WITH_OVERFLOW_TOP_ASSERT_SVH
`define CHAR_GRID_STORE_WITH_OVERFLOW_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CGS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grid store check failed");
// Next-cycle implication.
`define CGS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grid store check failed");
`endif

>>> hdl/cgs_pkg.sv
//------------------------------------------------------------------------------
// cgs_pkg
// Shared constants and types of the character grid store.
//------------------------------------------------------------------------------
package cgs_pkg;
	localparam int MAX_WIDTH      = 64;
	localparam int MAX_HEIGHT     = 64;
	localparam int OVERFLOW_DEPTH = 16;
	localparam int COORD_BITS     = 16;
	localparam int CHAR_BITS      = 21;
	localparam int DIM_BITS       = 7;
	localparam int COL_BITS       = $clog2(MAX_WIDTH);
	localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
	localparam int CELLS          = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_BITS      = $clog2(CELLS);
	localparam int OV_BITS        = (OVERFLOW_DEPTH > 1) ? $clog2(OVERFLOW_DEPTH) : 1;
	localparam int OV_CNT_BITS    = $clog2(OVERFLOW_DEPTH + 1);
	// cell word: {written, slime, char}
	localparam int CELL_BITS      = CHAR_BITS + 2;
	// overflow word: {x, y, slime, char}
	localparam int OV_WORD_BITS   = 2 * COORD_BITS + 1 + CHAR_BITS;

	typedef enum logic [2:0] {
		ACT_BEGIN = 3'd0, ACT_LOAD = 3'd1, ACT_END = 3'd2,
		ACT_READ = 3'd3, ACT_WRITE = 3'd4, ACT_SLIME = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_CLIPPED = 2'd1, ST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_SEPARATOR = 2'd0, CFG_MIRROR = 2'd1, CFG_FILL = 2'd2, CFG_OUTSIDE = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CLEAR, S_CELL_RD, S_CELL_WR, S_OV_RD, S_OV_CHK,
		S_MIR_RDA, S_MIR_RDB, S_MIR_WRA, S_MIR_WRB, S_OUT
	} state_t;
endpackage

>>> hdl/cgs_ram.sv
//------------------------------------------------------------------------------
// cgs_ram
// Generic single-port RAM with registered read.
//------------------------------------------------------------------------------
module cgs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

>>> hdl/char_grid_store_with_overflow_top.sv
//------------------------------------------------------------------------------
// char_grid_store_with_overflow_top
// Character grid store: box cells in RAM plus a linear overflow table.
//------------------------------------------------------------------------------
// One request at a time. Reads inside the box take a cell RAM read; writes and
// slime updates inside the box take a cell RAM read and write, and the result
// then goes to the output register. Points outside the box scan the overflow
// RAM entry by entry, reading each entry and then checking it. Begin load
// sweeps all MAX_WIDTH*MAX_HEIGHT (4096) cells of the cell RAM to clear it. End
// load with mirroring swaps the row halves through the single RAM port: each
// swapped pair is read A, read B, write A, write B, plus one step per row. A
// finished result waits in the output register, so the next request is taken
// while it is held; that request's own result then waits until the register
// frees. Right after reset the block clears the whole cell RAM before it
// takes a request; config writes are taken at any time. Cells hold
// {written, slime, char}.
//------------------------------------------------------------------------------
module char_grid_store_with_overflow_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [20:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    action,
	input  logic signed [15:0]            x_coord,
	input  logic signed [15:0]            y_coord,
	input  logic [20:0]                   char_in,
	input  logic                          slime_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [20:0]                   char_out,
	output logic                          slime_out,
	output logic                          present,
	output logic [6:0]                    grid_width,
	output logic [6:0]                    grid_height,
	output logic                          grid_empty,
	output logic [1:0]                    status
);
	import cgs_pkg::*;

	// config registers
	logic [CHAR_BITS-1:0] sep_q, fill_q, outside_q;
	logic                 mirror_q;

	// grid bookkeeping
	logic [DIM_BITS-1:0]  load_row_q, load_col_q, longest_q, box_w_q, box_h_q;
	logic                 empty_q, loading_q;
	logic [OV_CNT_BITS-1:0] ov_cnt_q;

	// captured request
	logic [2:0]            act_q;
	logic [COORD_BITS-1:0] x_q, y_q;
	logic [CHAR_BITS-1:0]  ch_q;
	logic                  sl_q;
	logic [ADDR_BITS-1:0]  addr_q;

	// sequencer
	state_t state_q, state_d;
	logic [ADDR_BITS-1:0]  clr_q;
	logic [OV_BITS-1:0]    ov_idx_q;
	logic [ROW_BITS-1:0]   mr_q;
	logic [COL_BITS-1:0]   mc_q;
	logic [CELL_BITS-1:0]  mir_a_q;
	logic                  boot_q;

	// working result of the request in progress
	logic [CHAR_BITS-1:0]  wk_ch_q;
	logic                  wk_sl_q, wk_pr_q;
	status_t               wk_st_q;

	// result register
	logic                  out_valid_q;
	logic [CHAR_BITS-1:0]  r_ch_q;
	logic                  r_sl_q, r_pr_q;
	status_t               r_st_q;
	logic [DIM_BITS-1:0]   r_w_q, r_h_q;
	logic                  r_em_q;

	// RAM ports
	logic                    c_we, o_we;
	logic [ADDR_BITS-1:0]    c_addr;
	logic [CELL_BITS-1:0]    c_wdata, c_rdata;
	logic [OV_BITS-1:0]      o_addr;
	logic [OV_WORD_BITS-1:0] o_wdata, o_rdata;

	cgs_ram #(.WIDTH(CELL_BITS), .DEPTH(CELLS)) u_cells (
		.clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata)
	);
	cgs_ram #(.WIDTH(OV_WORD_BITS), .DEPTH(OVERFLOW_DEPTH)) u_ovf (
		.clk(clk), .we(o_we), .addr(o_addr), .wdata(o_wdata), .rdata(o_rdata)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);

	// in-box test on the incoming request
	logic in_box;
	logic [ADDR_BITS-1:0] in_addr;
	always_comb begin
		in_box = !x_coord[COORD_BITS-1] && !y_coord[COORD_BITS-1]
			&& ($unsigned(x_coord) < COORD_BITS'(box_w_q))
			&& ($unsigned(y_coord) < COORD_BITS'(box_h_q));
		in_addr = {y_coord[ROW_BITS-1:0], x_coord[COL_BITS-1:0]};
	end

	// load character decode
	logic ld_store;
	assign ld_store = (load_row_q < DIM_BITS'(MAX_HEIGHT))
		&& (load_col_q < DIM_BITS'(MAX_WIDTH));

	// mirror pair addresses
	logic [COL_BITS-1:0]  mc_far;
	logic [DIM_BITS-1:0]  half_w;
	assign mc_far = COL_BITS'(box_w_q - DIM_BITS'(1) - DIM_BITS'(mc_q));
	assign half_w = box_w_q >> 1;

	// overflow entry match
	logic ov_hit;
	logic [CHAR_BITS-1:0] ov_ch;
	logic ov_sl;
	assign ov_hit = (o_rdata[OV_WORD_BITS-1 -: COORD_BITS] == x_q)
		&& (o_rdata[CHAR_BITS+1 +: COORD_BITS] == y_q);
	assign ov_sl = o_rdata[CHAR_BITS];
	assign ov_ch = o_rdata[CHAR_BITS-1:0];
	logic ov_last;
	assign ov_last = (OV_CNT_BITS'(ov_idx_q) + OV_CNT_BITS'(1)) >= ov_cnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (action)
						ACT_BEGIN: state_d = S_CLEAR;
						ACT_LOAD:  state_d = S_OUT;
						ACT_END: begin
							if (loading_q && mirror_q) state_d = S_MIR_RDA;
							else state_d = S_OUT;
						end
						ACT_READ, ACT_WRITE, ACT_SLIME: begin
							if (in_box) state_d = S_CELL_RD;
							else if (ov_cnt_q != '0) state_d = S_OV_RD;
							else state_d = S_OV_CHK;
						end
						default: state_d = S_OUT;
					endcase
				end
			end
			// the clear after reset gives no result
			S_CLEAR: begin
				if (clr_q == ADDR_BITS'(CELLS - 1)) state_d = boot_q ? S_IDLE : S_OUT;
			end
			S_CELL_RD: state_d = S_CELL_WR;
			S_CELL_WR: state_d = S_OUT;
			S_OV_RD:   state_d = S_OV_CHK;
			S_OV_CHK: begin
				if (ov_cnt_q == '0 || ov_hit || ov_last) state_d = S_OUT;
				else state_d = S_OV_RD;
			end
			S_MIR_RDA: begin
				if (DIM_BITS'(mc_q) >= half_w) begin
					if (DIM_BITS'(mr_q) + DIM_BITS'(1) < box_h_q) state_d = S_MIR_RDA;
					else state_d = S_OUT;
				end else begin
					state_d = S_MIR_RDB;
				end
			end
			S_MIR_RDB: state_d = S_MIR_WRA;
			S_MIR_WRA: state_d = S_MIR_WRB;
			S_MIR_WRB: state_d = S_MIR_RDA;
			S_OUT:     if (!out_valid_q || out_ready) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		c_we = 1'b0; c_addr = addr_q; c_wdata = c_rdata;
		o_we = 1'b0; o_addr = ov_idx_q; o_wdata = {x_q, y_q, sl_q, ch_q};
		case (state_q)
			S_IDLE: begin
				c_addr = in_addr;
				if (in_valid && action == ACT_LOAD && loading_q
					&& char_in != sep_q && ld_store) begin
					c_we = 1'b1;
					c_addr = {load_row_q[ROW_BITS-1:0], load_col_q[COL_BITS-1:0]};
					c_wdata = {1'b1, 1'b0, char_in};
				end
			end
			S_CLEAR: begin
				c_we = 1'b1; c_addr = clr_q; c_wdata = '0;
			end
			S_CELL_WR: begin
				if (act_q == ACT_WRITE) begin
					c_we = 1'b1; c_wdata = {1'b1, 1'b0, ch_q};
				end else if (act_q == ACT_SLIME) begin
					c_we = 1'b1; c_wdata = {c_rdata[CELL_BITS-1], sl_q, c_rdata[CHAR_BITS-1:0]};
				end
			end
			S_OV_CHK: begin
				if (act_q == ACT_WRITE || act_q == ACT_SLIME) begin
					if (ov_cnt_q != '0 && ov_hit) begin
						o_we = 1'b1;
						o_wdata = (act_q == ACT_WRITE) ? {x_q, y_q, 1'b0, ch_q}
							: {x_q, y_q, sl_q, ov_ch};
					end else if ((ov_cnt_q == '0 || ov_last)
						&& ov_cnt_q < OV_CNT_BITS'(OVERFLOW_DEPTH)) begin
						o_we = 1'b1;
						o_addr = OV_BITS'(ov_cnt_q);
						o_wdata = (act_q == ACT_WRITE) ? {x_q, y_q, 1'b0, ch_q}
							: {x_q, y_q, sl_q, outside_q};
					end
				end
			end
			S_MIR_RDA: c_addr = {mr_q, mc_q};
			S_MIR_RDB: c_addr = {mr_q, mc_far};
			S_MIR_WRA: begin
				c_we = 1'b1; c_addr = {mr_q, mc_q}; c_wdata = c_rdata;
			end
			S_MIR_WRB: begin
				c_we = 1'b1; c_addr = {mr_q, mc_far}; c_wdata = mir_a_q;
			end
			default: ;
		endcase
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= CHAR_BITS'(10); mirror_q <= 1'b0;
			fill_q <= CHAR_BITS'(32); outside_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SEPARATOR: sep_q <= cfg_data;
				CFG_MIRROR:    mirror_q <= cfg_data[0];
				CFG_FILL:      fill_q <= cfg_data;
				CFG_OUTSIDE:   outside_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q <= action; x_q <= x_coord; y_q <= y_coord;
			ch_q <= char_in; sl_q <= slime_in; addr_q <= in_addr;
		end
		if (state_q == S_MIR_RDB) mir_a_q <= c_rdata;
	end

	// end-of-load sizes
	logic [DIM_BITS-1:0] rows_v;
	always_comb begin
		rows_v = load_row_q + ((load_col_q != '0) ? DIM_BITS'(1) : DIM_BITS'(0));
		if (rows_v > DIM_BITS'(MAX_HEIGHT)) rows_v = DIM_BITS'(MAX_HEIGHT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR; clr_q <= '0; ov_idx_q <= '0;
			mr_q <= '0; mc_q <= '0;
			load_row_q <= '0; load_col_q <= '0; longest_q <= '0;
			box_w_q <= DIM_BITS'(1); box_h_q <= DIM_BITS'(1); empty_q <= 1'b1;
			loading_q <= 1'b0; ov_cnt_q <= '0;
			wk_ch_q <= '0; wk_sl_q <= 1'b0; wk_pr_q <= 1'b0; wk_st_q <= ST_OK;
			out_valid_q <= 1'b0; r_ch_q <= '0; r_sl_q <= 1'b0; r_pr_q <= 1'b0;
			r_st_q <= ST_OK; r_w_q <= DIM_BITS'(1); r_h_q <= DIM_BITS'(1);
			r_em_q <= 1'b1;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					clr_q <= '0; ov_idx_q <= '0; mr_q <= '0; mc_q <= '0;
					wk_ch_q <= '0; wk_sl_q <= 1'b0; wk_pr_q <= 1'b0; wk_st_q <= ST_OK;
					if (in_valid) begin
						case (action)
							ACT_BEGIN: begin
								load_row_q <= '0; load_col_q <= '0; longest_q <= '0;
								ov_cnt_q <= '0; loading_q <= 1'b1;
							end
							ACT_LOAD: begin
								if (loading_q) begin
									if (char_in == sep_q) begin
										load_col_q <= '0;
										if (load_row_q < DIM_BITS'(MAX_HEIGHT))
											load_row_q <= load_row_q + DIM_BITS'(1);
									end else begin
										if (!ld_store) wk_st_q <= ST_CLIPPED;
										if (load_col_q < DIM_BITS'(MAX_WIDTH)) begin
											load_col_q <= load_col_q + DIM_BITS'(1);
											if (load_col_q + DIM_BITS'(1) > longest_q)
												longest_q <= load_col_q + DIM_BITS'(1);
										end
									end
								end
							end
							ACT_END: begin
								if (loading_q) begin
									loading_q <= 1'b0;
									box_w_q <= (longest_q == '0) ? DIM_BITS'(1) : longest_q;
									box_h_q <= (rows_v == '0) ? DIM_BITS'(1) : rows_v;
									empty_q <= (longest_q == '0);
								end
							end
							default: ;
						endcase
					end
				end
				S_CLEAR: clr_q <= clr_q + ADDR_BITS'(1);
				S_CELL_WR: begin
					if (act_q == ACT_READ) begin
						wk_pr_q <= 1'b1;
						wk_sl_q <= c_rdata[CHAR_BITS];
						wk_ch_q <= c_rdata[CELL_BITS-1] ? c_rdata[CHAR_BITS-1:0]
							: (empty_q ? outside_q : fill_q);
					end
				end
				S_OV_CHK: begin
					if (ov_cnt_q != '0 && ov_hit) begin
						if (act_q == ACT_READ) begin
							wk_pr_q <= 1'b1; wk_ch_q <= ov_ch; wk_sl_q <= ov_sl;
						end
					end else if (ov_cnt_q == '0 || ov_last) begin
						if (act_q == ACT_WRITE || act_q == ACT_SLIME) begin
							if (ov_cnt_q < OV_CNT_BITS'(OVERFLOW_DEPTH))
								ov_cnt_q <= ov_cnt_q + OV_CNT_BITS'(1);
							else wk_st_q <= ST_FULL;
						end
					end else begin
						ov_idx_q <= ov_idx_q + OV_BITS'(1);
					end
				end
				S_MIR_RDA: begin
					if (DIM_BITS'(mc_q) >= half_w) begin
						mc_q <= '0;
						if (DIM_BITS'(mr_q) + DIM_BITS'(1) < box_h_q)
							mr_q <= mr_q + ROW_BITS'(1);
					end
				end
				S_MIR_WRB: mc_q <= mc_q + COL_BITS'(1);
				default: ;
			endcase

			// output register: load when free or being drained
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				r_ch_q <= wk_ch_q; r_sl_q <= wk_sl_q; r_pr_q <= wk_pr_q;
				r_st_q <= wk_st_q;
				r_w_q <= box_w_q; r_h_q <= box_h_q; r_em_q <= empty_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// set until the clear after reset is done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) boot_q <= 1'b1;
		else if (state_q == S_CLEAR && clr_q == ADDR_BITS'(CELLS - 1)) boot_q <= 1'b0;
	end

	assign out_valid   = out_valid_q;
	assign char_out    = r_ch_q;
	assign slime_out   = r_sl_q;
	assign present     = r_pr_q;
	assign grid_width  = r_w_q;
	assign grid_height = r_h_q;
	assign grid_empty  = r_em_q;
	assign status      = r_st_q;
endmodule

>>> hdl/cgs_checker.sv
//------------------------------------------------------------------------------
// cgs_checker
// Port-level checks of the character grid store.
//------------------------------------------------------------------------------
`include "char_grid_store_with_overflow_top_assert.svh"
module cgs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       present,
	input logic [1:0] status,
	input logic [6:0] grid_width,
	input logic [6:0] grid_height
);
	import cgs_pkg::*;

	`CGS_ASSERT_IMP(a_pres_ok, out_valid && present, status == ST_OK)
	`CGS_ASSERT_IMP(a_width, 1'b1, grid_width != 7'd0 && grid_height != 7'd0)
	`CGS_ASSERT_NXT(a_one_req, in_valid && in_ready, !in_ready)
	`CGS_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid)
endmodule

bind char_grid_store_with_overflow_top cgs_checker u_cgs_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .present(present),
	.status(status), .grid_width(grid_width), .grid_height(grid_height)
);

>>> test/cgs_grid_checker.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// cgs_grid_checker
// Watches the request and result channels of the character grid store, keeps
// its own model of the box cells and overflow table, and compares each result.
//------------------------------------------------------------------------------
module cgs_grid_checker
	import cgs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [20:0]            cfg_data,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [2:0]             action,
	input  logic signed [15:0]     x_coord,
	input  logic signed [15:0]     y_coord,
	input  logic [20:0]            char_in,
	input  logic                   slime_in,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [20:0]            char_out,
	input  logic                   slime_out,
	input  logic                   present,
	input  logic [6:0]             grid_width,
	input  logic [6:0]             grid_height,
	input  logic                   grid_empty,
	input  logic [1:0]             status,
	output int                     fail_count,
	output int                     pending
);
	typedef struct packed {
		logic [20:0] ch;
		logic        sl;
		logic        pr;
		logic [6:0]  w;
		logic [6:0]  h;
		logic        em;
		logic [1:0]  st;
	} grid_result_t;

	grid_result_t result_q[$];

	logic [20:0] sep_reg, fill_reg, outside_reg;
	logic        mirror_reg;
	logic [20:0] m_ch[CELLS];
	logic        m_wr[CELLS];
	logic        m_sl[CELLS];
	int          ld_row, ld_col, longest, bw, bh;
	logic        empty_f, loading;
	logic [15:0] ov_x[OVERFLOW_DEPTH], ov_y[OVERFLOW_DEPTH];
	logic [20:0] ov_ch[OVERFLOW_DEPTH];
	logic        ov_sl[OVERFLOW_DEPTH];
	int          ov_n;

	assign pending = result_q.size();

	function automatic int ov_lookup(logic [15:0] kx, logic [15:0] ky);
		for (int i = 0; i < ov_n; i++)
			if (ov_x[i] == kx && ov_y[i] == ky) return i;
		return -1;
	endfunction

	// apply one request to the model and return the result it should give
	function automatic grid_result_t grid_step(logic [2:0] act, logic signed [15:0] x,
		logic signed [15:0] y, logic [20:0] ch, logic sl);
		grid_result_t r;
		bit   inbox;
		int   a, idx, rows, b;
		logic [20:0] tc;
		logic tw, ts;
		r = '0;
		inbox = x >= 0 && x < bw && y >= 0 && y < bh;
		a = inbox ? int'(y) * MAX_WIDTH + int'(x) : 0;
		case (act)
		ACT_BEGIN: begin
			for (int i = 0; i < CELLS; i++) begin
				m_wr[i] = 1'b0;
				m_sl[i] = 1'b0;
			end
			ld_row = 0; ld_col = 0; longest = 0; ov_n = 0;
			loading = 1'b1;
		end
		ACT_LOAD: if (loading) begin
			if (ch == sep_reg) begin
				ld_col = 0;
				if (ld_row < MAX_HEIGHT) ld_row++;
			end else begin
				if (ld_row < MAX_HEIGHT && ld_col < MAX_WIDTH) begin
					b = ld_row * MAX_WIDTH + ld_col;
					m_ch[b] = ch; m_wr[b] = 1'b1; m_sl[b] = 1'b0;
				end else r.st = ST_CLIPPED;
				if (ld_col < MAX_WIDTH) ld_col++;
				if (ld_col > longest) longest = ld_col;
			end
		end
		ACT_END: if (loading) begin
			loading = 1'b0;
			rows = ld_row + (ld_col > 0 ? 1 : 0);
			if (rows > MAX_HEIGHT) rows = MAX_HEIGHT;
			bw = longest < 1 ? 1 : longest;
			bh = rows < 1 ? 1 : rows;
			empty_f = longest < 1;
			if (mirror_reg)
				for (int rr = 0; rr < bh; rr++)
					for (int c = 0; c < bw / 2; c++) begin
						a = rr * MAX_WIDTH + c;
						b = rr * MAX_WIDTH + bw - 1 - c;
						tc = m_ch[a]; tw = m_wr[a]; ts = m_sl[a];
						m_ch[a] = m_ch[b]; m_wr[a] = m_wr[b]; m_sl[a] = m_sl[b];
						m_ch[b] = tc; m_wr[b] = tw; m_sl[b] = ts;
					end
		end
		ACT_READ: if (inbox) begin
			r.pr = 1'b1;
			r.sl = m_sl[a];
			r.ch = m_wr[a] ? m_ch[a] : (empty_f ? outside_reg : fill_reg);
		end else begin
			idx = ov_lookup(x, y);
			if (idx >= 0) begin
				r.pr = 1'b1; r.ch = ov_ch[idx]; r.sl = ov_sl[idx];
			end
		end
		ACT_WRITE: if (inbox) begin
			m_ch[a] = ch; m_wr[a] = 1'b1; m_sl[a] = 1'b0;
		end else begin
			idx = ov_lookup(x, y);
			if (idx >= 0) begin
				ov_ch[idx] = ch; ov_sl[idx] = 1'b0;
			end else if (ov_n < OVERFLOW_DEPTH) begin
				ov_x[ov_n] = x; ov_y[ov_n] = y; ov_ch[ov_n] = ch; ov_sl[ov_n] = 1'b0;
				ov_n++;
			end else r.st = ST_FULL;
		end
		ACT_SLIME: if (inbox) m_sl[a] = sl;
		else begin
			idx = ov_lookup(x, y);
			if (idx >= 0) ov_sl[idx] = sl;
			else if (ov_n < OVERFLOW_DEPTH) begin
				ov_x[ov_n] = x; ov_y[ov_n] = y; ov_ch[ov_n] = outside_reg;
				ov_sl[ov_n] = sl;
				ov_n++;
			end else r.st = ST_FULL;
		end
		default: ;
		endcase
		r.w = bw[6:0]; r.h = bh[6:0]; r.em = empty_f;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grid_result_t got, want;
		if (!arst_n) begin
			sep_reg = 21'd10; mirror_reg = 1'b0; fill_reg = 21'd32; outside_reg = '0;
			for (int i = 0; i < CELLS; i++) begin
				m_wr[i] = 1'b0; m_sl[i] = 1'b0; m_ch[i] = '0;
			end
			ld_row = 0; ld_col = 0; longest = 0; bw = 1; bh = 1;
			empty_f = 1'b1; loading = 1'b0; ov_n = 0;
			fail_count = 0;
			result_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				case (cfg_idx_t'(cfg_index))
				CFG_SEPARATOR: sep_reg = cfg_data;
				CFG_MIRROR:    mirror_reg = cfg_data[0];
				CFG_FILL:      fill_reg = cfg_data;
				CFG_OUTSIDE:   outside_reg = cfg_data;
				default: ;
				endcase
			if (out_valid && out_ready) begin
				got = '{char_out, slime_out, present, grid_width, grid_height,
					grid_empty, status};
				if (result_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%t unexpected result %h", $realtime, got);
				end else begin
					want = result_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"%t mismatch: exp ch=%h sl=%b pr=%b w=%0d h=%0d",
								" em=%b st=%0d, got ch=%h sl=%b pr=%b w=%0d h=%0d",
								" em=%b st=%0d"},
								$realtime, want.ch, want.sl, want.pr, want.w, want.h,
								want.em, want.st, got.ch, got.sl, got.pr, got.w,
								got.h, got.em, got.st);
					end
				end
			end
			if (in_valid && in_ready)
				result_q.insert(result_q.size(),
					grid_step(action, x_coord, y_coord, char_in, slime_in));
		end
	end
endmodule

>>> test/tb_char_grid_store_with_overflow_top.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_char_grid_store_with_overflow_top
// Stimulus for the character grid store: loads of random text, reads, writes
// and slime updates in and around the box, with config changes between phases.
//------------------------------------------------------------------------------
module tb_char_grid_store_with_overflow_top;
	import cgs_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = '0;
	logic [20:0]       cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [2:0]        action = '0;
	logic signed [15:0] x_coord = '0;
	logic signed [15:0] y_coord = '0;
	logic [20:0]       char_in = '0;
	logic              slime_in = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [20:0]       char_out;
	logic              slime_out;
	logic              present;
	logic [6:0]        grid_width;
	logic [6:0]        grid_height;
	logic              grid_empty;
	logic [1:0]        status;
	int                fail_count;
	int                pending;

	// idle percentages for sender and receiver, changed per phase
	int                send_idle = 0;
	int                recv_stall = 0;
	// separator currently programmed, so the text generator can use it
	logic [20:0]       cur_sep = 21'd10;

	always #5 clk = ~clk;

	char_grid_store_with_overflow_top dut (.*);

	cgs_grid_checker u_checker (.*);

	// receiver: random stall per cycle
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall);

	// send one request; valid stays up until in_ready is seen high after an edge,
	// and stays up into the next request when there is no idle gap
	task automatic send_req(action_t act, logic signed [15:0] x, logic signed [15:0] y,
		logic [20:0] ch, logic sl);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		x_coord  <= x;
		y_coord  <= y;
		char_in  <= ch;
		slime_in <= sl;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_raw(logic [2:0] act);
		send_req(action_t'(act), 16'($urandom), 16'($urandom), 21'($urandom),
			1'($urandom));
	endtask

	// drop valid and wait for a clock edge
	task automatic stop_sending();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// config writes only while idle: drain results, then wait out the block
	task automatic write_reg(cfg_idx_t idx, logic [20:0] val);
		stop_sending();
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_SEPARATOR) cur_sep = val;
	endtask

	function automatic logic [20:0] rand_char();
		case ($urandom_range(3))
		0: return 21'h1FFFFF;
		1: return 21'($urandom_range(1114111));
		default: return 21'($urandom_range(32, 126));
		endcase
	endfunction

	// a load of rows up to max_w wide and max_h tall
	task automatic load_grid(int max_w, int max_h);
		int rows, len;
		logic [20:0] c;
		send_req(ACT_BEGIN, '0, '0, '0, 1'b0);
		rows = $urandom_range(max_h);
		for (int r = 0; r < rows; r++) begin
			len = $urandom_range(max_w);
			for (int k = 0; k < len; k++) begin
				c = rand_char();
				if (c == cur_sep) c = c ^ 21'd1;
				send_req(ACT_LOAD, 16'($urandom), 16'($urandom), c, 1'($urandom));
			end
			// last row sometimes without separator
			if (r != rows - 1 || $urandom_range(1))
				send_req(ACT_LOAD, '0, '0, cur_sep, 1'b0);
		end
		send_req(ACT_END, '0, '0, '0, 1'b0);
	endtask

	// point mostly near the box, sometimes anywhere
	task automatic rand_access();
		logic signed [15:0] x, y;
		int a;
		if ($urandom_range(9) == 0) begin
			x = 16'($urandom); y = 16'($urandom);
		end else begin
			x = 16'($signed($urandom_range(grid_width + 4)) - 3);
			y = 16'($signed($urandom_range(grid_height + 4)) - 3);
		end
		a = $urandom_range(99);
		if (a < 40)      send_req(ACT_READ, x, y, '0, 1'b0);
		else if (a < 70) send_req(ACT_WRITE, x, y, rand_char(), 1'($urandom));
		else if (a < 95) send_req(ACT_SLIME, x, y, rand_char(), 1'($urandom));
		else             send_raw(3'($urandom_range(6, 7)));
	endtask

	task automatic run_phase(int n_acc);
		for (int i = 0; i < n_acc; i++) begin
			if ($urandom_range(40) == 0) load_grid(6, 5);
			else rand_access();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: access before any load, stray load and end, unknown actions
		send_req(ACT_READ, 16'sd0, 16'sd0, '0, 1'b0);
		send_req(ACT_LOAD, '0, '0, 21'd65, 1'b0);
		send_req(ACT_END, '0, '0, '0, 1'b0);
		send_raw(3'd6);
		send_raw(3'd7);
		send_req(ACT_SLIME, 16'sh7FFF, -16'sh8000, '0, 1'b1);
		send_req(ACT_READ, 16'sh7FFF, -16'sh8000, '0, 1'b0);
		// empty load, then read box cell (outside char)
		send_req(ACT_BEGIN, '0, '0, '0, 1'b0);
		send_req(ACT_LOAD, '0, '0, 21'd10, 1'b0);
		send_req(ACT_END, '0, '0, '0, 1'b0);
		send_req(ACT_READ, 16'sd0, 16'sd0, '0, 1'b0);
		// oversized row: 66 characters clipped at 64 columns, the 17th new point finds the table full
		send_req(ACT_BEGIN, '0, '0, '0, 1'b0);
		for (int k = 0; k < 66; k++) send_req(ACT_LOAD, '0, '0, 21'h1FFFFF, 1'b0);
		send_req(ACT_END, '0, '0, '0, 1'b0);
		for (int k = 0; k < 17; k++)
			send_req(ACT_WRITE, -16'sd1, 16'(k), 21'(k), 1'b0);
		send_req(ACT_SLIME, -16'sd2, 16'sd0, '0, 1'b1);
		send_req(ACT_WRITE, 16'sd63, 16'sd0, 21'd0, 1'b0);
		send_req(ACT_SLIME, 16'sd0, 16'sd0, '0, 1'b1);
		send_req(ACT_READ, 16'sd0, 16'sd0, '0, 1'b0);
		// overflow rows past 64 rows
		send_req(ACT_BEGIN, '0, '0, '0, 1'b0);
		for (int k = 0; k < 66; k++) begin
			send_req(ACT_LOAD, '0, '0, 21'd66, 1'b0);
			send_req(ACT_LOAD, '0, '0, 21'd10, 1'b0);
		end
		send_req(ACT_END, '0, '0, '0, 1'b0);
		send_req(ACT_READ, 16'sd0, 16'sd63, '0, 1'b0);

		// random phases: each idle mode twice, each phase with its own config setting
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
			0: begin send_idle = 0;  recv_stall = 0;  end
			1: begin send_idle = 75; recv_stall = 0;  end
			2: begin send_idle = 0;  recv_stall = 75; end
			default: begin send_idle = 14; recv_stall = 14; end
			endcase
			write_reg(CFG_MIRROR, 21'(p & 1));
			write_reg(CFG_SEPARATOR, p == 5 ? 21'h1FFFFF : (p == 3 ? 21'd0 : 21'd10));
			write_reg(CFG_FILL, p == 2 ? 21'h1FFFFF : (p == 6 ? 21'd0 : rand_char()));
			write_reg(CFG_OUTSIDE, p == 4 ? 21'h1FFFFF : rand_char());
			load_grid(6, 5);
			if (p == 7) load_grid(64, 3);
			run_phase(80);
			// sender holds off until every result is back
			stop_sending();
			while (pending != 0) @(posedge clk);
		end

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#40ms;
		$display("FAIL");
		$finish;
	end
endmodule
